>>> src/ppd_pkg.sv
`timescale 1ns / 1ps
// Package for the path point decimator: shared widths, saturation constants,
// the distance unit result type and a saturating add. Depends on nothing.
package ppd_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int CFG_W           = 24;
    localparam int LEN_W           = 32;

    localparam logic [LEN_W-1:0] LEN_SAT = '1;
    // (2^32-1)^2: a sum of squares at or above this gives a saturated distance
    localparam logic [63:0]      SQ_LIM  = 64'hFFFF_FFFE_0000_0001;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] gap;
    } dist_res_t;

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? LEN_SAT : s[LEN_W-1:0];
    endfunction

endpackage

>>> src/ppd_dist.sv
`timescale 1ns / 1ps
// Distance unit: one shared squarer and a bit-serial integer square root.
// Depends on ppd_pkg.
module ppd_dist #(
    parameter int COORD_WIDTH = ppd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [COORD_WIDTH-1:0] x,
    input  logic signed [COORD_WIDTH-1:0] y,
    input  logic signed [COORD_WIDTH-1:0] px,
    input  logic signed [COORD_WIDTH-1:0] py,
    output ppd_pkg::dist_res_t            res
);

    localparam int MAG_W  = COORD_WIDTH + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int EXT_W  = (SUM_W > 64) ? SUM_W : 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ADD,
        ST_ROOT
    } state_t;

    state_t                   state_reg, state_next;
    logic [MAG_W-1:0]         ax_reg, ax_next, ay_reg, ay_next;
    logic [SQ_W-1:0]          prod_reg, prod_next, sq_reg, sq_next;
    logic [RAD_W-1:0]         rad_reg, rad_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     sat_reg, sat_next;
    logic                     done_reg, done_next;
    logic [ppd_pkg::LEN_W-1:0] dist_reg, dist_next;

    logic [MAG_W-1:0] dx, dy, mul_op;
    logic [SQ_W-1:0]  prod;
    logic [SUM_W-1:0] sum;
    logic [REM_W-1:0] trial_rem, trial_sub;
    logic             fits;

    assign dx = {x[COORD_WIDTH-1], x} - {px[COORD_WIDTH-1], px};
    assign dy = {y[COORD_WIDTH-1], y} - {py[COORD_WIDTH-1], py};

    // Shared squarer: x difference first, then y difference
    assign mul_op = (state_reg == ST_SQ_X) ? ax_reg : ay_reg;
    assign prod   = mul_op * mul_op;
    assign sum    = SUM_W'(sq_reg) + SUM_W'(prod_reg);

    // One root digit per cycle
    assign trial_rem = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial_sub = {root_reg, 2'b01};
    assign fits      = trial_rem >= trial_sub;

    always_comb begin
        state_next = state_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        prod_next  = prod_reg;
        sq_next    = sq_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;
        done_next  = 1'b0;
        dist_next  = dist_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    ax_next    = dx[MAG_W-1] ? (MAG_W'(0) - dx) : dx;
                    ay_next    = dy[MAG_W-1] ? (MAG_W'(0) - dy) : dy;
                    state_next = ST_SQ_X;
                end
            end
            ST_SQ_X: begin
                prod_next  = prod;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                sq_next    = prod_reg;
                prod_next  = prod;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                rad_next   = RAD_W'(sum);
                sat_next   = EXT_W'(sum) >= EXT_W'(ppd_pkg::SQ_LIM);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                rad_next  = rad_reg << 2;
                rem_next  = fits ? (trial_rem - trial_sub) : trial_rem;
                root_next = {root_reg[ROOT_W-2:0], fits};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                    dist_next  = sat_reg ? ppd_pkg::LEN_SAT
                                         : ppd_pkg::LEN_W'(root_next);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        prod_reg <= prod_next;
        sq_reg   <= sq_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        sat_reg  <= sat_next;
        dist_reg <= dist_next;
    end

    assign res.done = done_reg;
    assign res.gap  = dist_reg;

endmodule

>>> src/ppd_out_stage.sv
`timescale 1ns / 1ps
// Output register for result requests: holds one result until taken.
// Depends on nothing.
module ppd_out_stage #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> src/path_point_decimator_top.sv
`timescale 1ns / 1ps
// Path point decimator top level: sequencer, path state and result queue.
// Depends on ppd_pkg, ppd_dist and ppd_out_stage.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-------------------------------------------------
//  s_       | in        | tdata: point_x, point_y; tlast: path_end
//  m_       | out       | tdata: kept_x, kept_y, arc_length; tuser: has_point;
//           |           | tlast: last_of_path
//  cfg_     | in        | cfg_wdata: min_point_spacing (write only)
//
// The first point of a path is queued directly. For any later point the
// distance unit squares both differences on one multiplier, then runs
// COORD_WIDTH + 2 root digits, one per cycle; the sequencer then
// accumulates the distance, decides, and queues each result in turn.
// Reset is synchronous, active low, and clears the path state and the
// spacing register. A stalled m_ side holds the last result in the output
// register; s_tready stays low until all results of a point are queued.
module path_point_decimator_top #(
    parameter int COORD_WIDTH = ppd_pkg::COORD_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_we,
    input  logic [ppd_pkg::CFG_W-1:0]   cfg_wdata,   // min_point_spacing
    // input points
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata, // point_x, point_y
    input  logic                        s_tlast,     // path_end
    // kept points
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [((2*COORD_WIDTH+ppd_pkg::LEN_W+7)/8)*8-1:0] m_tdata,
                                                     // kept_x, kept_y, arc_length
    output logic                        m_tuser,     // has_point
    output logic                        m_tlast      // last_of_path
);

    localparam int CW    = COORD_WIDTH;
    localparam int LW    = ppd_pkg::LEN_W;
    localparam int OUT_W = ((2*CW+LW+7)/8)*8;
    localparam int RES_W = OUT_W + 2;

    // kept point count of the current path
    localparam logic [1:0] KC_NONE = 2'd0;
    localparam logic [1:0] KC_ONE  = 2'd1;
    localparam logic [1:0] KC_TWO  = 2'd2;
    localparam logic [1:0] KC_MANY = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIST,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    // Result word: {last_of_path, has_point, padded tdata}
    function automatic logic [RES_W-1:0] pack(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y,
                                              input logic [LW-1:0] len,
                                              input logic          has,
                                              input logic          last);
        logic [RES_W-1:0] r;
        r = '0;
        r[CW-1:0]       = x;
        r[2*CW-1:CW]    = y;
        r[2*CW+LW-1:2*CW] = len;
        r[OUT_W]        = has;
        r[OUT_W+1]      = last;
        return r;
    endfunction

    state_t                  state_reg, state_next;
    logic [ppd_pkg::CFG_W-1:0] mps_reg;
    logic [1:0]              kc_reg, kc_next;
    logic signed [CW-1:0]    prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [CW-1:0]    first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [CW-1:0]    held_x_reg, held_x_next, held_y_reg, held_y_next;
    logic [LW-1:0]           held_len_reg, held_len_next;
    logic [LW-1:0]           since_reg, since_next, total_reg, total_next;
    logic signed [CW-1:0]    in_x_reg, in_x_next, in_y_reg, in_y_next;
    logic                    in_end_reg, in_end_next;
    logic [RES_W-1:0]        slot0_reg, slot0_next, slot1_reg, slot1_next;
    logic [1:0]              n_reg, n_next;
    logic                    idx_reg, idx_next;

    logic signed [CW-1:0]    s_x, s_y;
    logic                    dist_start;
    ppd_pkg::dist_res_t      dist_res;
    logic                    keep;
    logic [1:0]              kc_a, n_a;
    logic [CW:0]             mid_x_sum, mid_y_sum;
    logic                    push_valid, push_ready;
    logic [RES_W-1:0]        push_data, out_q;

    assign s_x = s_tdata[CW-1:0];
    assign s_y = s_tdata[2*CW-1:CW];

    assign s_tready = (state_reg == ST_IDLE);

    ppd_dist #(
        .COORD_WIDTH(CW)
    ) u_dist (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (dist_start),
        .x      (s_x),
        .y      (s_y),
        .px     (prev_x_reg),
        .py     (prev_y_reg),
        .res    (dist_res)
    );

    // Keep once the distance since the last kept point exceeds the spacing
    assign keep = since_reg > LW'(mps_reg);

    // Floor midpoint: the sign-extended sum shifted right by one. The second
    // kept point is the incoming one when it was kept just now.
    assign mid_x_sum = {first_x_reg[CW-1], first_x_reg}
                     + ((kc_reg == KC_ONE) ? {in_x_reg[CW-1], in_x_reg}
                                           : {held_x_reg[CW-1], held_x_reg});
    assign mid_y_sum = {first_y_reg[CW-1], first_y_reg}
                     + ((kc_reg == KC_ONE) ? {in_y_reg[CW-1], in_y_reg}
                                           : {held_y_reg[CW-1], held_y_reg});

    always_comb begin
        state_next    = state_reg;
        kc_next       = kc_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        first_x_next  = first_x_reg;
        first_y_next  = first_y_reg;
        held_x_next   = held_x_reg;
        held_y_next   = held_y_reg;
        held_len_next = held_len_reg;
        since_next    = since_reg;
        total_next    = total_reg;
        in_x_next     = in_x_reg;
        in_y_next     = in_y_reg;
        in_end_next   = in_end_reg;
        slot0_next    = slot0_reg;
        slot1_next    = slot1_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        dist_start    = 1'b0;
        push_valid    = 1'b0;
        push_data     = idx_reg ? slot1_reg : slot0_reg;
        kc_a          = kc_reg;
        n_a           = 2'd0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    in_x_next   = s_x;
                    in_y_next   = s_y;
                    in_end_next = s_tlast;
                    if (kc_reg == KC_NONE) begin
                        // First point of a path: keep it at arc length zero
                        slot0_next   = pack(s_x, s_y, '0, 1'b1, s_tlast);
                        n_next       = 2'd1;
                        idx_next     = 1'b0;
                        first_x_next = s_x;
                        first_y_next = s_y;
                        prev_x_next  = s_x;
                        prev_y_next  = s_y;
                        since_next   = '0;
                        total_next   = '0;
                        kc_next      = s_tlast ? KC_NONE : KC_ONE;
                        state_next   = ST_EMIT;
                    end else begin
                        dist_start = 1'b1;
                        state_next = ST_DIST;
                    end
                end
            end
            ST_DIST: begin
                if (dist_res.done) begin
                    since_next  = ppd_pkg::sat_add(since_reg, dist_res.gap);
                    total_next  = ppd_pkg::sat_add(total_reg, dist_res.gap);
                    prev_x_next = in_x_reg;
                    prev_y_next = in_y_reg;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (keep) begin
                    since_next = '0;
                    case (kc_reg)
                        KC_ONE: begin
                            // Hold the second kept point back for a possible midpoint
                            held_x_next   = in_x_reg;
                            held_y_next   = in_y_reg;
                            held_len_next = total_reg;
                            kc_a          = KC_TWO;
                        end
                        KC_TWO: begin
                            slot0_next = pack(held_x_reg, held_y_reg, held_len_reg,
                                              1'b1, 1'b0);
                            slot1_next = pack(in_x_reg, in_y_reg, total_reg,
                                              1'b1, in_end_reg);
                            n_a        = 2'd2;
                            kc_a       = KC_MANY;
                        end
                        default: begin
                            slot0_next = pack(in_x_reg, in_y_reg, total_reg,
                                              1'b1, in_end_reg);
                            n_a        = 2'd1;
                        end
                    endcase
                end
                if (in_end_reg) begin
                    if (kc_a == KC_TWO) begin
                        // Exactly two kept points: insert the midpoint first
                        slot0_next = pack(mid_x_sum[CW:1], mid_y_sum[CW:1],
                                          held_len_next >> 1, 1'b1, 1'b0);
                        slot1_next = pack(held_x_next, held_y_next, held_len_next,
                                          1'b1, 1'b1);
                        n_a        = 2'd2;
                    end else if (kc_a == KC_ONE || !keep) begin
                        // Bare end marker: the final point was not kept, so no result carries the path end
                        slot0_next = pack('0, '0, '0, 1'b0, 1'b1);
                        n_a        = 2'd1;
                    end
                    kc_a       = KC_NONE;
                    since_next = '0;
                    total_next = '0;
                end
                kc_next    = kc_a;
                n_next     = n_a;
                idx_next   = 1'b0;
                state_next = (n_a == 2'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                push_valid = 1'b1;
                if (push_ready) begin
                    idx_next = 1'b1;
                    if (2'(idx_reg) + 2'd1 == n_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mps_reg    <= '0;
            kc_reg     <= KC_NONE;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            since_reg  <= '0;
            total_reg  <= '0;
            n_reg      <= 2'd0;
            idx_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            kc_reg     <= kc_next;
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
            since_reg  <= since_next;
            total_reg  <= total_next;
            n_reg      <= n_next;
            idx_reg    <= idx_next;
            if (cfg_we) begin
                mps_reg <= cfg_wdata;
            end
        end
        first_x_reg  <= first_x_next;
        first_y_reg  <= first_y_next;
        held_x_reg   <= held_x_next;
        held_y_reg   <= held_y_next;
        held_len_reg <= held_len_next;
        in_x_reg     <= in_x_next;
        in_y_reg     <= in_y_next;
        in_end_reg   <= in_end_next;
        slot0_reg    <= slot0_next;
        slot1_reg    <= slot1_next;
    end

    // Output register parts the result queue from the m_ side
    ppd_out_stage #(
        .WIDTH(RES_W)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (push_valid),
        .in_ready (push_ready),
        .in_data  (push_data),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_q)
    );

    assign m_tdata = out_q[OUT_W-1:0];
    assign m_tuser = out_q[OUT_W];
    assign m_tlast = out_q[OUT_W+1];

    // A point that opens a path goes straight to the result queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && kc_reg == KC_NONE) |=> (state_reg == ST_EMIT))
        else $error("first point did not go to the result queue");

    // The distance unit only finishes while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        dist_res.done |-> (state_reg == ST_DIST))
        else $error("distance result outside of the wait state");

    // Queuing the final result of a path means the path state is already cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push_valid && push_ready && push_data[OUT_W+1]) |-> (kc_reg == KC_NONE))
        else $error("path end queued while a path is still open");

    // A bare end marker is zero and closes the path
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("malformed end marker");

endmodule

>>> test/path_point_decimator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for path_point_decimator_top: a table of directed paths,
// then random paths at several spacing settings, checked against an in-bench model.
// Depends on ppd_pkg and the path_point_decimator_top RTL.
module testbench;

    localparam int               CW      = ppd_pkg::COORD_WIDTH_DEF;
    localparam int               CFG_W   = ppd_pkg::CFG_W;
    localparam int               LEN_W   = ppd_pkg::LEN_W;
    localparam logic [LEN_W-1:0] LEN_SAT = ppd_pkg::LEN_SAT;
    localparam logic [63:0]      SQ_LIM  = ppd_pkg::SQ_LIM;
    localparam int S_W = ((2*CW+7)/8)*8;
    localparam int M_W = ((2*CW+LEN_W+7)/8)*8;

    // Cycles the block may still be busy on a point that yields no result.
    localparam int SETTLE        = CW + 16;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int HOLD_CYCLES   = 600;
    localparam int HOLD_AT       = 250;
    localparam int PHASE_ITEMS   = 145;
    localparam int NUM_PHASES    = 8;
    localparam int SAT_PATH_LEN  = 200;

    // Progress of the current path, in the order kept points are found.
    typedef enum logic [1:0] {PATH_IDLE, PATH_ONE, PATH_HELD, PATH_STREAM} path_phase_t;

    typedef struct packed {
        logic [CW-1:0]    x;
        logic [CW-1:0]    y;
        logic [LEN_W-1:0] arc;
        logic             has;
        logic             last;
    } kept_pt_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          fin;
        logic          typed;
        logic [1:0]    n;
        kept_pt_t      e0;
        kept_pt_t      e1;
    } path_row_t;

    localparam kept_pt_t NONE = '0;

    // Directed paths at the reset spacing of 0. Rows marked typed carry their
    // results written out by hand; the rest go through the model below.
    path_row_t directed_rows [0:19] = '{
        // single-point path at opposite coordinate extremes
        '{24'h7FFFFF, 24'h800000, 1, 1, 1, '{8388607, -8388608, 0, 1, 1}, NONE},
        // two kept points: midpoint inserted, last point carries the end
        '{0, 0, 0, 1, 1, '{0, 0, 0, 1, 0}, NONE},
        '{3, 4, 0, 1, 0, NONE, NONE},
        '{3, 4, 1, 1, 2, '{1, 2, 2, 1, 0}, '{3, 4, 5, 1, 1}},
        // full-range jumps, then a repeated final point gives a bare end marker
        '{-8388608, -8388608, 0, 1, 1, '{-8388608, -8388608, 0, 1, 0}, NONE},
        '{8388607, 8388607, 0, 0, 0, NONE, NONE},
        '{-8388608, 8388607, 0, 0, 0, NONE, NONE},
        '{-8388608, 8388607, 1, 1, 1, '{0, 0, 0, 0, 1}, NONE},
        // negative midpoint sums round toward minus infinity
        '{-3, -5, 0, 1, 1, '{-3, -5, 0, 1, 0}, NONE},
        '{-4, -4, 1, 1, 2, '{-4, -5, 0, 1, 0}, '{-4, -4, 1, 1, 1}},
        // only the first point kept: bare end marker
        '{5, 5, 0, 1, 1, '{5, 5, 0, 1, 0}, NONE},
        '{5, 5, 1, 1, 1, '{0, 0, 0, 0, 1}, NONE},
        // streaming path whose final point is itself kept: no marker
        '{0, 0, 0, 1, 1, '{0, 0, 0, 1, 0}, NONE},
        '{1, 0, 0, 1, 0, NONE, NONE},
        '{2, 0, 0, 1, 2, '{1, 0, 1, 1, 0}, '{2, 0, 2, 1, 0}},
        '{3, 0, 1, 1, 1, '{3, 0, 3, 1, 1}, NONE},
        // second kept point is the final point
        '{0, 0, 0, 1, 1, '{0, 0, 0, 1, 0}, NONE},
        '{10, 0, 1, 1, 2, '{5, 0, 5, 1, 0}, '{10, 0, 10, 1, 1}},
        // midpoint of opposite corners sums to -1
        '{8388607, -8388608, 0, 1, 1, '{8388607, -8388608, 0, 1, 0}, NONE},
        '{-8388608, 8388607, 1, 0, 0, NONE, NONE}
    };

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata   = '0;
    logic             s_tlast   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [M_W-1:0]   m_tdata;
    logic             m_tuser;
    logic             m_tlast;

    // Model state of the decimator.
    logic [CFG_W-1:0] spacing    = '0;
    logic [CW-1:0]    last_x     = '0;
    logic [CW-1:0]    last_y     = '0;
    logic [CW-1:0]    start_x    = '0;
    logic [CW-1:0]    start_y    = '0;
    logic [CW-1:0]    held_x     = '0;
    logic [CW-1:0]    held_y     = '0;
    logic [LEN_W-1:0] held_arc   = '0;
    logic [LEN_W-1:0] since_keep = '0;
    logic [LEN_W-1:0] path_len   = '0;
    path_phase_t      kept       = PATH_IDLE;

    kept_pt_t step_res [$];
    kept_pt_t kept_due [$];

    bit steady      = 1'b0;
    int hold_left   = 0;
    bit held_once   = 1'b0;
    int idle_cycles = 0;
    int mismatches  = 0;
    int results_seen = 0;
    int saturated   = 0;
    int bare_ends   = 0;
    int points_sent = 0;
    int paths_sent  = 0;
    int settings    = 0;

    path_point_decimator_top #(
        .COORD_WIDTH (CW)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    function automatic logic [LEN_W-1:0] len_add(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? LEN_SAT : s[LEN_W-1:0];
    endfunction

    // Largest r with r*r <= n, one result bit at a time from the top.
    function automatic logic [31:0] floor_root(logic [63:0] n);
        logic [31:0] r;
        logic [63:0] c;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            c = {32'd0, r | (32'd1 << i)};
            if (c * c <= n)
                r = r | (32'd1 << i);
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] point_gap(logic [CW-1:0] x, logic [CW-1:0] y);
        longint dx;
        longint dy;
        logic [63:0] sq;
        dx = longint'($signed(x)) - longint'($signed(last_x));
        dy = longint'($signed(y)) - longint'($signed(last_y));
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sq = 64'(dx * dx) + 64'(dy * dy);
        if (sq >= SQ_LIM)
            return LEN_SAT;
        return floor_root(sq);
    endfunction

    // Floor of the mean of two signed coordinates.
    function automatic logic [CW-1:0] half_sum(logic [CW-1:0] a, logic [CW-1:0] b);
        logic [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        return s[CW:1];
    endfunction

    // Advance the model by one point and leave its results in step_res.
    function automatic void advance_path(logic [CW-1:0] x, logic [CW-1:0] y, logic fin);
        logic [LEN_W-1:0] d;
        logic keep;
        step_res.delete();
        if (kept == PATH_IDLE) begin
            start_x = x;
            start_y = y;
            last_x = x;
            last_y = y;
            since_keep = '0;
            path_len = '0;
            step_res.insert(step_res.size(), '{x, y, '0, 1'b1, fin});
            kept = fin ? PATH_IDLE : PATH_ONE;
            return;
        end
        d = point_gap(x, y);
        since_keep = len_add(since_keep, d);
        path_len = len_add(path_len, d);
        last_x = x;
        last_y = y;
        keep = since_keep > LEN_W'(spacing);
        if (keep) begin
            since_keep = '0;
            case (kept)
                PATH_ONE: begin
                    held_x = x;
                    held_y = y;
                    held_arc = path_len;
                    kept = PATH_HELD;
                end
                PATH_HELD: begin
                    step_res.insert(step_res.size(),
                                    '{held_x, held_y, held_arc, 1'b1, 1'b0});
                    step_res.insert(step_res.size(), '{x, y, path_len, 1'b1, fin});
                    kept = PATH_STREAM;
                end
                default: step_res.insert(step_res.size(), '{x, y, path_len, 1'b1, fin});
            endcase
        end
        if (fin) begin
            if (kept == PATH_HELD) begin
                step_res.insert(step_res.size(),
                                '{half_sum(start_x, held_x), half_sum(start_y, held_y),
                                  held_arc >> 1, 1'b1, 1'b0});
                step_res.insert(step_res.size(), '{held_x, held_y, held_arc, 1'b1, 1'b1});
            end else if (kept == PATH_ONE || !keep) begin
                step_res.insert(step_res.size(), '{'0, '0, '0, 1'b0, 1'b1});
            end
            kept = PATH_IDLE;
            since_keep = '0;
            path_len = '0;
        end
    endfunction

    // Offer one point, with random idle cycles ahead of it unless steady, and
    // queue what it should produce once it is accepted.
    task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic fin, input bit typed = 1'b0, input int n = 0,
                              input kept_pt_t e0 = '0, input kept_pt_t e1 = '0);
        logic [S_W-1:0] word;
        word = '0;
        word[CW-1:0] = x;
        word[2*CW-1:CW] = y;
        while (!steady && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tlast <= fin;
        do @(posedge aclk); while (!s_tready);
        advance_path(x, y, fin);
        if (typed) begin
            if (n >= 1) kept_due.insert(kept_due.size(), e0);
            if (n >= 2) kept_due.insert(kept_due.size(), e1);
        end else begin
            foreach (step_res[i]) kept_due.insert(kept_due.size(), step_res[i]);
        end
        points_sent++;
        if (fin) paths_sent++;
    endtask

    // Hold off new requests until every expected result is out and the block
    // has had time to finish a point that yields none.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (kept_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_spacing(input logic [CFG_W-1:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        spacing = v;
        settings++;
    endtask

    // Result side: check each accepted result, then pick the next tready.
    always @(posedge aclk) begin
        kept_pt_t got;
        kept_pt_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[CW-1:0];
            got.y = m_tdata[2*CW-1:CW];
            got.arc = m_tdata[2*CW+LEN_W-1:2*CW];
            got.has = m_tuser;
            got.last = m_tlast;
            results_seen++;
            if (got.arc == LEN_SAT) saturated++;
            if (!got.has) bare_ends++;
            if (kept_due.size() == 0) begin
                $error("unexpected result: kept_x %0d kept_y %0d arc_length %0d",
                       $signed(got.x), $signed(got.y), got.arc);
                mismatches++;
            end else begin
                want = kept_due.pop_front();
                if (got.x !== want.x) begin
                    $error("kept_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
                    mismatches++;
                end
                if (got.y !== want.y) begin
                    $error("kept_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
                    mismatches++;
                end
                if (got.arc !== want.arc) begin
                    $error("arc_length: expected %0d, got %0d", want.arc, got.arc);
                    mismatches++;
                end
                if (got.has !== want.has) begin
                    $error("has_point: expected %0d, got %0d", want.has, got.has);
                    mismatches++;
                end
                if (got.last !== want.last) begin
                    $error("last_of_path: expected %0d, got %0d", want.last, got.last);
                    mismatches++;
                end
            end
        end
        // One long hold-off lets the block back up and stall its input side.
        if (!held_once && results_seen >= HOLD_AT) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 13);
        end
    end

    // Watchdog: give up after too many cycles with no traffic at all.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("timeout after %0d quiet cycles, %0d results outstanding",
                     idle_cycles, kept_due.size());
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [CFG_W-1:0] plan [NUM_PHASES];
        logic [CW-1:0]    px;
        logic [CW-1:0]    py;
        int               produced;
        int               len;
        int               step_max;
        bit               paused;

        plan = '{24'hFFFFFF, 24'd1, 24'd1000, 24'd0, 24'd0, 24'd100, 24'd0, 24'd50000};
        plan[3] = CFG_W'($urandom);
        plan[6] = CFG_W'($urandom_range(200000, 2000));
        paused = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].fin,
                       directed_rows[i].typed, directed_rows[i].n,
                       directed_rows[i].e0, directed_rows[i].e1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_spacing(plan[p]);
            // Run one whole phase with neither side idling.
            steady = (p == 2);
            produced = 0;
            step_max = int'(plan[p] / 2) + 3;
            if (p == 5) begin
                // Bounce between opposite corners long enough for the arc length to saturate.
                for (int k = 0; k < SAT_PATH_LEN; k++) begin
                    px = k[0] ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
                    send_point(px, px, k == SAT_PATH_LEN - 1);
                end
                produced = SAT_PATH_LEN;
            end
            while (produced < PHASE_ITEMS) begin
                if (p == 3 && !paused && produced > PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    drain();
                end
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 11)
                                               : $urandom_range(10, 1);
                px = CW'($urandom);
                py = CW'($urandom);
                for (int k = 0; k < len; k++) begin
                    if (k > 0) begin
                        if ($urandom_range(9) == 0) begin
                            // noise: a jump anywhere in the coordinate range
                            px = CW'($urandom);
                            py = CW'($urandom);
                        end else begin
                            px = px + CW'(int'($urandom_range(2 * step_max, 0)) - step_max);
                            py = py + CW'(int'($urandom_range(2 * step_max, 0)) - step_max);
                        end
                    end
                    send_point(px, py, k == len - 1);
                end
                produced += len;
            end
        end
        steady = 1'b0;
        drain();

        $display("covered %0d points in %0d paths over %0d spacing settings",
                 points_sent, paths_sent, settings + 1);
        $display("checked %0d results: %0d bare end markers, %0d saturated arc lengths",
                 results_seen, bare_ends, saturated);
        if (mismatches == 0 && kept_due.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> path_point_decimator_top.f
src/ppd_pkg.sv
src/ppd_dist.sv
src/ppd_out_stage.sv
src/path_point_decimator_top.sv
test/path_point_decimator_tb.sv
